### hdl/ffea_pkg.sv
// shared types and constants for the first-fit extent allocator
// no dependencies; imported by ffea_table and first_fit_extent_allocator_top
`default_nettype none

package ffea_pkg;

  localparam int unsigned MAX_EXTENTS_DEF = 8;
  localparam int unsigned HEAP_WORDS      = 256;
  localparam int unsigned AW              = 9;
  localparam logic [AW-1:0] LIMIT_RESET   = 9'd256;

  typedef struct packed {
    logic [AW-1:0] end_addr;
    logic [AW-1:0] start_addr;
  } extent_t;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_FULL     = 2'd1,
    STATUS_NOSPACE  = 2'd2,
    STATUS_NOTFOUND = 2'd3
  } status_e;

  typedef enum logic {
    KIND_ALLOC = 1'b0,
    KIND_FREE  = 1'b1
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ASCAN,
    ST_ASHIFT,
    ST_PLACE,
    ST_FSCAN,
    ST_FSHIFT,
    ST_RESP
  } state_e;

endpackage

`default_nettype wire

### hdl/ffea_table.sv
// extent table: one write port, one read port with registered read data
// depends on ffea_pkg for the extent_t entry type
`default_nettype none

module ffea_table #(
  parameter int unsigned DEPTH = 8,
  parameter int unsigned IW    = 3
) (
  input  wire logic             clk_i,
  input  wire logic             wr_en_i,
  input  wire logic [IW-1:0]    wr_addr_i,
  input  ffea_pkg::extent_t     wr_data_i,
  input  wire logic [IW-1:0]    rd_addr_i,
  output ffea_pkg::extent_t     rd_data_o
);
  import ffea_pkg::*;

  extent_t mem [DEPTH];
  extent_t rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_q <= mem[rd_addr_i];
  end

  assign rd_data_o = rd_q;

endmodule

`default_nettype wire

### hdl/first_fit_extent_allocator_top.sv
// first-fit extent allocator top level: request sequencer, result register, limit register
// depends on ffea_pkg and ffea_table
`default_nettype none

// Keeps a sorted table of up to MAX_EXTENTS allocated extents [start, end) in word
// offsets and serves one request at a time. An allocate (tuser = 0) walks the gaps
// in address order, one gap per cycle, and takes the first one at least
// request_size words long; later entries then move up one place per cycle and
// the new extent is written. A free (tuser = 1) walks the table for the first
// extent starting at free_address, then moves the later entries down one place
// per cycle. A table-full allocate or a free on an empty table goes straight from
// acceptance to the result step, and a result still held in the output register
// stretches the last step. The pace is set by the extent table with one read and
// one write port: every scan step and every move is one table read and, for moves,
// one write. The result register lets the next request be accepted while the last
// result still waits for m_axis_tready. The user must write heap_limit through
// cfg_we_i and cfg_wdata_i only while the block is idle; the block does not enforce
// this. Values above the heap size act as the heap size. The table has no reset;
// only entries below the extent count are ever used.
module first_fit_extent_allocator_top #(
  parameter int unsigned MAX_EXTENTS = ffea_pkg::MAX_EXTENTS_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // request stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,  // [8:0] request_size, [17:9] free_address, rest zero
  input  wire logic [0:0]  s_axis_tuser,  // [0] kind
  // result stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata,  // [8:0] granted_address, rest zero
  output logic [1:0]       m_axis_tuser,  // [1:0] status
  // heap_limit register
  input  wire logic        cfg_we_i,
  input  wire logic [8:0]  cfg_wdata_i
);
  import ffea_pkg::*;

  localparam int unsigned CW = $clog2(MAX_EXTENTS + 1);
  localparam int unsigned IW = (MAX_EXTENTS > 1) ? $clog2(MAX_EXTENTS) : 1;

  state_e        state_q, state_d;
  logic [CW-1:0] count_q, count_d;     // live extents
  logic [CW-1:0] idx_q, idx_d;         // scan position or move pointer
  logic [CW-1:0] slot_q, slot_d;       // table slot of the new extent
  logic [AW-1:0] base_q, base_d;       // start of the chosen gap
  logic [AW-1:0] prev_end_q, prev_end_d;
  logic [AW-1:0] size_q, size_d;
  logic [AW-1:0] faddr_q, faddr_d;
  logic [AW-1:0] limit_q;
  status_e       res_status_q, res_status_d;
  logic [AW-1:0] res_addr_q, res_addr_d;
  logic          out_valid_q, out_valid_d;
  status_e       out_status_q, out_status_d;
  logic [AW-1:0] out_addr_q, out_addr_d;

  // table port
  logic          tbl_we;
  logic [IW-1:0] tbl_waddr;
  extent_t       tbl_wdata;
  logic [IW-1:0] tbl_raddr;
  extent_t       tbl_rdata;

  // shared gap unit: one add and one compare
  logic [AW-1:0] limit_eff;
  logic [AW-1:0] gap_end;
  logic [AW:0]   need_end;
  logic          gap_fits;
  logic [CW-1:0] idx_inc, idx_dec, idx_dec2, count_dec;
  logic          s_accept;

  assign limit_eff = (limit_q > AW'(HEAP_WORDS)) ? AW'(HEAP_WORDS) : limit_q;
  // last gap runs up to the heap limit, the others up to the next extent
  assign gap_end   = (idx_q == count_q) ? limit_eff : tbl_rdata.start_addr;
  assign need_end  = {1'b0, prev_end_q} + {1'b0, size_q};
  assign gap_fits  = ({1'b0, gap_end} >= need_end);

  assign idx_inc   = idx_q + CW'(1);
  assign idx_dec   = idx_q - CW'(1);
  assign idx_dec2  = idx_q - CW'(2);
  assign count_dec = count_q - CW'(1);

  assign s_axis_tready = (state_q == ST_IDLE);
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  ffea_table #(
    .DEPTH (MAX_EXTENTS),
    .IW    (IW)
  ) u_table (
    .clk_i     (clk_i),
    .wr_en_i   (tbl_we),
    .wr_addr_i (tbl_waddr),
    .wr_data_i (tbl_wdata),
    .rd_addr_i (tbl_raddr),
    .rd_data_o (tbl_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      limit_q     <= LIMIT_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    idx_q        <= idx_d;
    slot_q       <= slot_d;
    base_q       <= base_d;
    prev_end_q   <= prev_end_d;
    size_q       <= size_d;
    faddr_q      <= faddr_d;
    res_status_q <= res_status_d;
    res_addr_q   <= res_addr_d;
    out_status_q <= out_status_d;
    out_addr_q   <= out_addr_d;
  end

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    idx_d        = idx_q;
    slot_d       = slot_q;
    base_d       = base_q;
    prev_end_d   = prev_end_q;
    size_d       = size_q;
    faddr_d      = faddr_q;
    res_status_d = res_status_q;
    res_addr_d   = res_addr_q;
    out_status_d = out_status_q;
    out_addr_d   = out_addr_q;
    out_valid_d  = out_valid_q && !m_axis_tready;
    tbl_we       = 1'b0;
    tbl_waddr    = '0;
    tbl_wdata    = '0;
    tbl_raddr    = idx_inc[IW-1:0];

    case (state_q)
      ST_IDLE: begin
        // entry 0 is fetched so the first scan step has it
        tbl_raddr = '0;
        if (s_accept) begin
          size_d     = s_axis_tdata[8:0];
          faddr_d    = s_axis_tdata[17:9];
          idx_d      = '0;
          prev_end_d = '0;
          res_addr_d = '0;
          if (kind_e'(s_axis_tuser[0]) == KIND_ALLOC) begin
            if (count_q >= CW'(MAX_EXTENTS)) begin
              res_status_d = STATUS_FULL;
              state_d      = ST_RESP;
            end else begin
              state_d = ST_ASCAN;
            end
          end else begin
            if (count_q == '0) begin
              res_status_d = STATUS_NOTFOUND;
              state_d      = ST_RESP;
            end else begin
              state_d = ST_FSCAN;
            end
          end
        end
      end

      ST_ASCAN: begin
        // read data holds entry idx; the gap checked is the one below it
        if (gap_fits) begin
          base_d = prev_end_q;
          slot_d = idx_q;
          if (idx_q == count_q) begin
            state_d = ST_PLACE;
          end else begin
            idx_d     = count_q;
            tbl_raddr = count_dec[IW-1:0];
            state_d   = ST_ASHIFT;
          end
        end else if (idx_q == count_q) begin
          res_status_d = STATUS_NOSPACE;
          state_d      = ST_RESP;
        end else begin
          prev_end_d = tbl_rdata.end_addr;
          idx_d      = idx_inc;
        end
      end

      ST_ASHIFT: begin
        // move entry idx-1 up to idx, fetch the one below
        tbl_we    = 1'b1;
        tbl_waddr = idx_q[IW-1:0];
        tbl_wdata = tbl_rdata;
        tbl_raddr = idx_dec2[IW-1:0];
        idx_d     = idx_dec;
        if (idx_dec == slot_q) begin
          state_d = ST_PLACE;
        end
      end

      ST_PLACE: begin
        tbl_we               = 1'b1;
        tbl_waddr            = slot_q[IW-1:0];
        tbl_wdata.start_addr = base_q;
        tbl_wdata.end_addr   = base_q + size_q;
        count_d              = count_q + CW'(1);
        res_status_d         = STATUS_OK;
        res_addr_d           = base_q;
        state_d              = ST_RESP;
      end

      ST_FSCAN: begin
        if (tbl_rdata.start_addr == faddr_q) begin
          // next entry is already being fetched
          idx_d   = idx_inc;
          state_d = ST_FSHIFT;
        end else if (idx_q == count_dec) begin
          res_status_d = STATUS_NOTFOUND;
          state_d      = ST_RESP;
        end else begin
          idx_d = idx_inc;
        end
      end

      ST_FSHIFT: begin
        if (idx_q == count_q) begin
          count_d      = count_dec;
          res_status_d = STATUS_OK;
          state_d      = ST_RESP;
        end else begin
          // move entry idx down to idx-1
          tbl_we    = 1'b1;
          tbl_waddr = idx_dec[IW-1:0];
          tbl_wdata = tbl_rdata;
          idx_d     = idx_inc;
        end
      end

      ST_RESP: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_addr_d   = res_addr_q;
          state_d      = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'd0, out_addr_q};
  assign m_axis_tuser  = out_status_q;

  // the table never holds more extents than it has slots
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(MAX_EXTENTS))
    else $error("extent count above table depth");

  // an accepted request keeps the block busy in the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_accept |=> !s_axis_tready)
    else $error("request accepted while previous one in flight");

  // the extent count moves only when an extent is placed or a free completes
  a_count_change: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(count_q) |-> ($past(state_q) == ST_PLACE || $past(state_q) == ST_FSHIFT))
    else $error("extent count changed outside place or free");

  // the table is written only while a request is in work
  a_write_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tbl_we |-> (state_q == ST_ASHIFT || state_q == ST_PLACE || state_q == ST_FSHIFT))
    else $error("table write outside a move or place step");

endmodule

`default_nettype wire

### verif/ffea_grant_checker.sv
`timescale 1ns / 100ps
// result checker for the first-fit extent allocator: mirrors the extent table,
// predicts status and granted address per request, compares each result transaction
// depends on ffea_pkg
module ffea_grant_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  input  logic              s_axis_tready,
  input  logic [23:0]       s_axis_tdata,
  input  logic [0:0]        s_axis_tuser,
  input  logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  input  logic [15:0]       m_axis_tdata,
  input  logic [1:0]        m_axis_tuser,
  input  logic              cfg_we_i,
  input  logic [8:0]        cfg_wdata_i,
  output int unsigned       fail_count,
  output int unsigned       outstanding
);
  import ffea_pkg::*;

  typedef struct {
    status_e       status;
    logic [AW-1:0] addr;
  } grant_t;

  extent_t       extents [MAX_EXTENTS_DEF];
  int            live_count;
  logic [AW-1:0] heap_limit;
  grant_t        grant_q [$];
  int unsigned   mismatches;

  // first gap in address order that holds size words; later entries move up
  function automatic grant_t place_extent(logic [AW-1:0] size);
    grant_t        g;
    int            lim;
    int            gap_lo;
    int            gap_hi;
    int            slot;
    int            base;
    int            i;
    logic [AW-1:0] end_w;
    g.status = STATUS_OK;
    g.addr   = '0;
    slot     = -1;
    base     = 0;
    lim      = (heap_limit > AW'(HEAP_WORDS)) ? int'(HEAP_WORDS) : int'(heap_limit);
    if (live_count >= MAX_EXTENTS_DEF) begin
      g.status = STATUS_FULL;
      return g;
    end
    for (i = 0; i <= live_count && slot < 0; i++) begin
      gap_lo = (i == 0) ? 0 : int'(extents[i-1].end_addr);
      gap_hi = (i == live_count) ? lim : int'(extents[i].start_addr);
      // a negative gap (limit below an extent) never fits
      if (gap_hi - gap_lo >= int'(size)) begin
        slot = i;
        base = gap_lo;
      end
    end
    if (slot < 0) begin
      g.status = STATUS_NOSPACE;
      return g;
    end
    for (i = live_count; i > slot; i--) extents[i] = extents[i-1];
    end_w = AW'(base + int'(size));
    extents[slot].start_addr = AW'(base);
    extents[slot].end_addr   = end_w;
    live_count++;
    g.addr = AW'(base);
    return g;
  endfunction

  // drop the first extent starting at addr; later entries move down
  function automatic grant_t release_extent(logic [AW-1:0] addr);
    grant_t g;
    int     hit;
    int     i;
    g.status = STATUS_OK;
    g.addr   = '0;
    hit      = -1;
    for (i = 0; i < live_count; i++)
      if (hit < 0 && extents[i].start_addr == addr) hit = i;
    if (hit < 0) begin
      g.status = STATUS_NOTFOUND;
      return g;
    end
    for (i = hit; i < live_count - 1; i++) extents[i] = extents[i+1];
    live_count--;
    return g;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    grant_t exp_g;
    if (!rst_ni) begin
      live_count = 0;
      heap_limit = LIMIT_RESET;
      mismatches = 0;
      grant_q.delete();
      fail_count  <= 0;
      outstanding <= 0;
    end else begin
      if (cfg_we_i) heap_limit = cfg_wdata_i;

      if (m_axis_tvalid && m_axis_tready) begin
        if (grant_q.size() == 0) begin
          $display("%0t: unexpected result: expected none, got status %0d tdata 0x%0h",
                   $time, m_axis_tuser, m_axis_tdata);
          mismatches++;
        end else begin
          exp_g = grant_q.pop_front();
          if (m_axis_tuser !== exp_g.status) begin
            $display("%0t: status mismatch: expected %0d, actual %0d",
                     $time, exp_g.status, m_axis_tuser);
            mismatches++;
          end
          if (m_axis_tdata !== {7'b0, exp_g.addr}) begin
            $display("%0t: granted_address mismatch: expected 0x%0h, actual 0x%0h",
                     $time, {7'b0, exp_g.addr}, m_axis_tdata);
            mismatches++;
          end
        end
      end

      if (s_axis_tvalid && s_axis_tready) begin
        if (kind_e'(s_axis_tuser[0]) == KIND_ALLOC)
          grant_q.push_back(place_extent(s_axis_tdata[8:0]));
        else
          grant_q.push_back(release_extent(s_axis_tdata[17:9]));
      end

      fail_count  <= mismatches;
      outstanding <= grant_q.size();
    end
  end

endmodule

### verif/tb_first_fit_extent_allocator_top.sv
`timescale 1ns / 100ps
// testbench top for first_fit_extent_allocator_top: clock, reset, request and
// heap_limit stimulus, result-side backpressure, verdict; depends on ffea_pkg,
// ffea_grant_checker and the block itself
module tb_first_fit_extent_allocator_top;
  import ffea_pkg::*;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata  = '0;  // [8:0] request_size, [17:9] free_address, rest zero
  logic [0:0]  s_axis_tuser  = '0;  // [0] kind
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;        // [8:0] granted_address, rest zero
  logic [1:0]  m_axis_tuser;        // [1:0] status
  logic        cfg_we_i      = 1'b0;
  logic [8:0]  cfg_wdata_i   = '0;

  int unsigned fail_count;
  int unsigned outstanding;

  // idle odds in percent, changed per stretch of the run
  int          tx_idle_pct   = 29;
  int          rx_stall_pct  = 55;

  // recently granted offsets, used to aim free requests at live extents
  logic [8:0]  recent_grants [$];

  always #1 clk_i = ~clk_i;

  first_fit_extent_allocator_top u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  ffea_grant_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .fail_count    (fail_count),
    .outstanding   (outstanding)
  );

  // result side backpressure, redrawn every cycle
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
  end

  // keep a short history of good grants (frees report 0, harmless as a hint)
  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready && m_axis_tuser == STATUS_OK) begin
      recent_grants.push_back(m_axis_tdata[8:0]);
      if (recent_grants.size() > 16) void'(recent_grants.pop_front());
    end
  end

  // one request transaction; tvalid only drops when the sender actually idles,
  // so back-to-back transactions never see a low and a high in the same step
  task automatic send_request(kind_e kind, logic [8:0] size, logic [8:0] addr);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {6'b0, addr, size};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // stop sending and wait until every expected result has come back
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0);
  endtask

  // heap_limit only changes with the block idle
  task automatic set_heap_limit(logic [8:0] lim);
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= lim;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // mostly alloc/free traffic aimed at live extents, some stray frees
  task automatic random_requests(int count);
    int         n;
    int         roll;
    logic [8:0] size;
    logic [8:0] addr;
    for (n = 0; n < count; n++) begin
      roll = $urandom_range(99);
      if (roll < 55) begin
        roll = $urandom_range(99);
        if (roll < 60)      size = 9'($urandom_range(16));
        else if (roll < 85) size = 9'($urandom_range(64));
        else if (roll < 95) size = 9'($urandom_range(256));
        else                size = roll[0] ? 9'd256 : 9'd0;
        send_request(KIND_ALLOC, size, 9'($urandom_range(256)));
      end else begin
        if (recent_grants.size() != 0 && $urandom_range(99) < 70)
          addr = recent_grants[$urandom_range(recent_grants.size() - 1)];
        else
          addr = 9'($urandom_range(256));
        send_request(KIND_FREE, 9'($urandom_range(256)), addr);
      end
    end
  endtask

  initial begin
    int         p;
    logic [8:0] lim;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty table, zero-size extents sharing a start, whole-heap extent
    send_request(KIND_FREE,  9'd0,   9'd0);    // not found on empty table
    send_request(KIND_ALLOC, 9'd0,   9'd0);    // zero-size at 0
    send_request(KIND_ALLOC, 9'd0,   9'd0);    // zero-length gap fits a zero size
    send_request(KIND_ALLOC, 9'd256, 9'd0);    // whole heap after two empty extents
    send_request(KIND_ALLOC, 9'd1,   9'd0);    // no space left
    send_request(KIND_FREE,  9'd0,   9'd0);    // duplicate starts: first one only
    send_request(KIND_FREE,  9'd0,   9'd0);
    send_request(KIND_FREE,  9'd0,   9'd0);
    send_request(KIND_FREE,  9'd0,   9'd256);  // not found, top address bit set
    // fill the table with power-of-two sizes, then hit table full
    for (p = 0; p < MAX_EXTENTS_DEF; p++)
      send_request(KIND_ALLOC, 9'(1 << p), 9'd0);
    send_request(KIND_ALLOC, 9'd0,   9'd0);    // full even for zero size
    send_request(KIND_ALLOC, 9'd256, 9'd0);
    send_request(KIND_FREE,  9'd0,   9'd3);    // free in the middle
    send_request(KIND_ALLOC, 9'd2,   9'd0);    // refill the hole

    // limit lowered below the last extents: trailing gap goes negative
    set_heap_limit(9'd100);
    send_request(KIND_FREE,  9'd0,   9'd127);
    send_request(KIND_ALLOC, 9'd200, 9'd0);    // no space
    send_request(KIND_ALLOC, 9'd2,   9'd0);    // first-fit into an inner gap

    // random stretches under several limits, idle pattern switching by thirds
    for (p = 0; p < 6; p++) begin
      case (p)
        0: lim = 9'd256;
        1: lim = 9'd1;
        2: lim = 9'($urandom_range(2, 255));
        3: lim = 9'd511;                       // above heap size, acts as heap size
        4: lim = 9'd200;
        default: lim = 9'd256;
      endcase
      set_heap_limit(lim);
      if (p == 2) begin
        tx_idle_pct  = 55;
        rx_stall_pct = 29;
      end else if (p == 4) begin
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
      end
      random_requests(130);
    end

    wait_drained();
    repeat (20) @(posedge clk_i);
    if (fail_count == 0 && outstanding == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // hard stop if the block hangs
  initial begin
    #1000000;
    $display("FAIL");
    $finish;
  end

endmodule
